### rtl/manchester_pulse_decoder_assert.svh
// Assertion macros for the pulse decoder.
`ifndef MANCHESTER_PULSE_DECODER_ASSERT_SVH
`define MANCHESTER_PULSE_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mpd_pkg.sv
// Types, constants and helpers shared by the pulse decoder modules.
package mpd_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int HALF_W     = 9;
  localparam int TOL_W      = 8;
  localparam int BITS_W     = 7;
  localparam int SETTLE_W   = 12;
  localparam int TICK_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int HEADER_PULSES_DEF = 16;
  localparam int MAX_BITS_DEF      = 96;
  localparam int SYNC_PULSES_DEF   = 3;
  localparam int TARGET_CAP        = 126;

  localparam logic [SAMPLE_W-1:0] LOW_THR_RST     = 8'd114;
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST    = 8'd140;
  localparam logic [HALF_W-1:0]   HALF_PERIOD_RST = 9'd192;
  localparam logic [TOL_W-1:0]    TOLERANCE_RST   = 8'd96;
  localparam logic [BITS_W-1:0]   EXP_BITS_RST    = 7'd32;
  localparam logic [SETTLE_W-1:0] SETTLE_RST      = 12'd2304;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR     = 3'd0,
    CFG_HIGH_THR    = 3'd1,
    CFG_HALF_PERIOD = 3'd2,
    CFG_TOLERANCE   = 3'd3,
    CFG_EXP_BITS    = 3'd4,
    CFG_SETTLE      = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_NO_HEADER = 2'd1,
    ST_SYNC_BAD  = 2'd2,
    ST_SHORT     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_HEADER = 3'd2,
    PH_SYNC   = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  typedef logic [TICK_W-1:0] tick_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        bit_pair;
    logic [1:0]        bit_total;
    logic [BITS_W-1:0] bit_index;
    logic              frame_done;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_thr;
    logic [SAMPLE_W-1:0] high_thr;
    logic [HALF_W-1:0]   half_period;
    logic [TOL_W-1:0]    tolerance;
    logic [BITS_W-1:0]   expected_bits;
    logic [SETTLE_W-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic run;
    logic restart;
    logic edge_fall;
  } meter_ctl_t;

  typedef struct packed {
    logic  done;
    tick_t len;
  } pulse_t;

  // p within [max(len - tol, 0), len + tol]
  function automatic logic near_len(tick_t p, tick_t len, logic [TOL_W-1:0] tol);
    logic [TICK_W:0] tol_x;
    logic [TICK_W:0] lo;
    logic [TICK_W:0] hi;
    tol_x = {{(TICK_W + 1 - TOL_W){1'b0}}, tol};
    lo = ({1'b0, len} > tol_x) ? ({1'b0, len} - tol_x) : '0;
    hi = {1'b0, len} + tol_x;
    return ({1'b0, p} >= lo) && ({1'b0, p} <= hi);
  endfunction

endpackage

### rtl/mpd_cfg.sv
// Configuration register file of the pulse decoder.
module mpd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output mpd_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_thr       <= mpd_pkg::LOW_THR_RST;
      cfg.high_thr      <= mpd_pkg::HIGH_THR_RST;
      cfg.half_period   <= mpd_pkg::HALF_PERIOD_RST;
      cfg.tolerance     <= mpd_pkg::TOLERANCE_RST;
      cfg.expected_bits <= mpd_pkg::EXP_BITS_RST;
      cfg.settle_ticks  <= mpd_pkg::SETTLE_RST;
    end else if (cfg_en) begin
      unique case (mpd_pkg::cfg_idx_t'(cfg_index))
        mpd_pkg::CFG_LOW_THR:     cfg.low_thr       <= cfg_data[mpd_pkg::SAMPLE_W-1:0];
        mpd_pkg::CFG_HIGH_THR:    cfg.high_thr      <= cfg_data[mpd_pkg::SAMPLE_W-1:0];
        mpd_pkg::CFG_HALF_PERIOD: cfg.half_period   <= cfg_data[mpd_pkg::HALF_W-1:0];
        mpd_pkg::CFG_TOLERANCE:   cfg.tolerance     <= cfg_data[mpd_pkg::TOL_W-1:0];
        mpd_pkg::CFG_EXP_BITS:    cfg.expected_bits <= cfg_data[mpd_pkg::BITS_W-1:0];
        mpd_pkg::CFG_SETTLE:      cfg.settle_ticks  <= cfg_data[mpd_pkg::SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/mpd_meter.sv
// Edge-to-edge pulse length measurement with hysteresis and timeout.
module mpd_meter (
  input  logic                         clk,
  input  logic                         rst,
  input  mpd_pkg::cfg_t                cfg,
  input  mpd_pkg::meter_ctl_t          ctl,
  input  logic [mpd_pkg::SAMPLE_W-1:0] sample,
  output mpd_pkg::pulse_t              pulse
);

  logic [1:0]     step;
  logic [1:0]     step_next;
  mpd_pkg::tick_t timeout_count;
  mpd_pkg::tick_t timeout_count_next;
  mpd_pkg::tick_t pulse_ticks;
  mpd_pkg::tick_t pulse_ticks_next;

  mpd_pkg::tick_t tc_inc;
  mpd_pkg::tick_t pt_inc;
  mpd_pkg::tick_t limit;
  logic           timed_out;
  logic           want_high;
  logic           hit;

  // 8 half periods; 9 + 3 bits fill the tick counter exactly
  assign limit     = {cfg.half_period, 3'b000};
  assign tc_inc    = timeout_count + 1'b1;
  assign timed_out = tc_inc > limit;
  assign pt_inc    = (step != 2'd0) ? pulse_ticks + 1'b1 : pulse_ticks;
  assign want_high = (step != 2'd1) == !ctl.edge_fall;
  assign hit       = want_high ? (sample >= cfg.high_thr) : (sample <= cfg.low_thr);

  assign pulse.done = timed_out || (hit && step == 2'd2);
  assign pulse.len  = timed_out ? '0 : pt_inc;

  always_comb begin
    step_next          = step;
    timeout_count_next = timeout_count;
    pulse_ticks_next   = pulse_ticks;
    if (ctl.restart || (ctl.run && pulse.done)) begin
      step_next          = 2'd0;
      timeout_count_next = '0;
      pulse_ticks_next   = '0;
    end else if (ctl.run) begin
      timeout_count_next = tc_inc;
      pulse_ticks_next   = (hit && step == 2'd0) ? '0 : pt_inc;
      step_next          = hit ? step + 2'd1 : step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= 2'd0;
      timeout_count <= '0;
      pulse_ticks   <= '0;
    end else begin
      step          <= step_next;
      timeout_count <= timeout_count_next;
      pulse_ticks   <= pulse_ticks_next;
    end
  end

endmodule

### rtl/mpd_frame.sv
// Frame sequencer: settle, header search, sync check and bit decoding.
module mpd_frame #(
  parameter int HEADER_PULSES = mpd_pkg::HEADER_PULSES_DEF,
  parameter int MAX_BITS      = mpd_pkg::MAX_BITS_DEF,
  parameter int SYNC_PULSES   = mpd_pkg::SYNC_PULSES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mpd_pkg::cfg_t       cfg,
  input  logic                fire,
  input  mpd_pkg::in_item_t   item,
  input  mpd_pkg::pulse_t     pulse,
  output mpd_pkg::meter_ctl_t mctl,
  output logic                res_valid,
  output mpd_pkg::out_item_t  res
);

  localparam int TRY_W  = $clog2(HEADER_PULSES + 1);
  localparam int SYNC_W = $clog2(SYNC_PULSES + 1);
  localparam int BITS_W = mpd_pkg::BITS_W;
  localparam int SETTLE_W_DEC = mpd_pkg::SETTLE_W;
  localparam logic [BITS_W-1:0] LIMIT =
    BITS_W'((MAX_BITS < mpd_pkg::TARGET_CAP) ? MAX_BITS : mpd_pkg::TARGET_CAP);

  mpd_pkg::phase_t               phase;
  mpd_pkg::phase_t               phase_next;
  logic                          edge_fall;
  logic                          edge_fall_next;
  logic [mpd_pkg::SETTLE_W-1:0]  settle_count;
  logic [mpd_pkg::SETTLE_W-1:0]  settle_count_next;
  logic [TRY_W-1:0]              header_tries;
  logic [TRY_W-1:0]              header_tries_next;
  logic [SYNC_W-1:0]             sync_count;
  logic [SYNC_W-1:0]             sync_count_next;
  logic [BITS_W-1:0]             bits_done;
  logic [BITS_W-1:0]             bits_done_next;

  logic                          sample_tick;
  logic                          measuring;
  logic                          pdone;
  mpd_pkg::tick_t                h_x;
  mpd_pkg::tick_t                len2;
  mpd_pkg::tick_t                len3;
  mpd_pkg::tick_t                len4;
  logic                          near2;
  logic                          near3;
  logic                          near4;
  logic [BITS_W-1:0]             target;
  logic [TRY_W:0]                tries_inc;
  logic [SYNC_W:0]               sync_inc;
  logic                          header_out;
  logic                          sync_full;
  logic [SETTLE_W_DEC-1:0]       settle_dec;
  logic [1:0]                    pair;
  logic [1:0]                    total;
  logic [BITS_W:0]               bits_sum;
  logic                          target_hit;

  assign sample_tick = fire && item.op == mpd_pkg::OP_SAMPLE;
  assign measuring   = phase == mpd_pkg::PH_HEADER || phase == mpd_pkg::PH_SYNC
                    || phase == mpd_pkg::PH_DATA;
  assign pdone       = sample_tick && measuring && pulse.done;

  assign mctl.run       = sample_tick && measuring;
  assign mctl.restart   = fire && item.op == mpd_pkg::OP_START;
  assign mctl.edge_fall = edge_fall;

  assign h_x   = {{(mpd_pkg::TICK_W - mpd_pkg::HALF_W){1'b0}}, cfg.half_period};
  assign len2  = {h_x[mpd_pkg::TICK_W-2:0], 1'b0};
  assign len4  = {h_x[mpd_pkg::TICK_W-3:0], 2'b00};
  assign len3  = len2 + h_x;
  assign near2 = mpd_pkg::near_len(pulse.len, len2, cfg.tolerance);
  assign near3 = mpd_pkg::near_len(pulse.len, len3, cfg.tolerance);
  assign near4 = mpd_pkg::near_len(pulse.len, len4, cfg.tolerance);

  assign target     = (cfg.expected_bits > LIMIT) ? LIMIT : cfg.expected_bits;
  assign tries_inc  = {1'b0, header_tries} + 1'b1;
  assign header_out = tries_inc >= (TRY_W + 1)'(HEADER_PULSES);
  assign sync_inc   = {1'b0, sync_count} + 1'b1;
  assign sync_full  = sync_inc >= (SYNC_W + 1)'(SYNC_PULSES);
  assign settle_dec = (settle_count != '0) ? settle_count - 1'b1 : settle_count;

  // data pulse decode; checks go shortest length first
  always_comb begin
    pair  = 2'b00;
    total = 2'd0;
    priority if (near2) begin
      pair  = edge_fall ? 2'b01 : 2'b00;
      total = 2'd1;
    end else if (near3) begin
      pair  = edge_fall ? 2'b00 : 2'b11;
      total = 2'd2;
    end else if (near4) begin
      pair  = edge_fall ? 2'b01 : 2'b10;
      total = 2'd2;
    end
  end

  assign bits_sum   = {1'b0, bits_done} + {{(BITS_W - 1){1'b0}}, total};
  assign target_hit = bits_sum >= {1'b0, target};

  // next state
  always_comb begin
    phase_next        = phase;
    edge_fall_next    = edge_fall;
    settle_count_next = settle_count;
    header_tries_next = header_tries;
    sync_count_next   = sync_count;
    bits_done_next    = bits_done;
    if (mctl.restart) begin
      edge_fall_next    = 1'b0;
      header_tries_next = '0;
      sync_count_next   = '0;
      bits_done_next    = '0;
      settle_count_next = cfg.settle_ticks;
      phase_next        = (cfg.settle_ticks == '0) ? mpd_pkg::PH_HEADER
                                                   : mpd_pkg::PH_SETTLE;
    end else if (sample_tick) begin
      unique case (phase)
        mpd_pkg::PH_SETTLE: begin
          settle_count_next = settle_dec;
          if (settle_dec == '0) phase_next = mpd_pkg::PH_HEADER;
        end
        mpd_pkg::PH_HEADER: begin
          if (pdone) begin
            if (near3) begin
              phase_next      = mpd_pkg::PH_SYNC;
              sync_count_next = '0;
            end else begin
              header_tries_next = tries_inc[TRY_W-1:0];
              if (header_out) phase_next = mpd_pkg::PH_IDLE;
            end
          end
        end
        mpd_pkg::PH_SYNC: begin
          if (pdone) begin
            if (!near2) begin
              phase_next = mpd_pkg::PH_IDLE;
            end else begin
              sync_count_next = sync_inc[SYNC_W-1:0];
              if (sync_full) begin
                bits_done_next = '0;
                phase_next     = (target == '0) ? mpd_pkg::PH_IDLE : mpd_pkg::PH_DATA;
              end
            end
          end
        end
        mpd_pkg::PH_DATA: begin
          if (pdone) begin
            if (total == 2'd0) begin
              phase_next = mpd_pkg::PH_IDLE;
            end else begin
              bits_done_next = bits_sum[BITS_W-1:0];
              if (!near2 && near3) edge_fall_next = !edge_fall;
              if (target_hit) phase_next = mpd_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid      = 1'b0;
    res            = '0;
    res.status     = mpd_pkg::ST_COMPLETE;
    if (pdone) begin
      unique case (phase)
        mpd_pkg::PH_HEADER: begin
          if (!near3 && header_out) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = mpd_pkg::ST_NO_HEADER;
          end
        end
        mpd_pkg::PH_SYNC: begin
          if (!near2) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
            res.status     = mpd_pkg::ST_SYNC_BAD;
          end else if (sync_full && target == '0) begin
            res_valid      = 1'b1;
            res.frame_done = 1'b1;
          end
        end
        mpd_pkg::PH_DATA: begin
          res_valid     = 1'b1;
          res.bit_index = bits_done;
          if (total == 2'd0) begin
            res.frame_done = 1'b1;
            res.status     = mpd_pkg::ST_SHORT;
          end else begin
            res.bit_pair   = pair;
            res.bit_total  = total;
            res.frame_done = target_hit;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mpd_pkg::PH_IDLE;
      edge_fall    <= 1'b0;
      settle_count <= '0;
      header_tries <= '0;
      sync_count   <= '0;
      bits_done    <= '0;
    end else begin
      phase        <= phase_next;
      edge_fall    <= edge_fall_next;
      settle_count <= settle_count_next;
      header_tries <= header_tries_next;
      sync_count   <= sync_count_next;
      bits_done    <= bits_done_next;
    end
  end

endmodule

### rtl/manchester_pulse_decoder.sv
// Top level of the Manchester pulse-width decoder.
//
//   channel   direction  handshake             payload
//   in        in         in_valid / in_stall   in_req  (op, sample)
//   out       out        out_valid / out_stall out_res (bit_pair .. status)
//   cfg       in         cfg_en                cfg_index, cfg_data
//
// One request per cycle sustained while no stalled result is held; a taken
// request goes into the input register, and the sequencer then writes its result
// into the result register. The whole tick update is one pass through the meter
// and sequencer, so frame state is ready for the next tick every cycle.
// Reset clears all control state and loads the register defaults.
// A stalled result holds the result register; the next request still
// lands in the input register, and in_stall rises only once both are full.
`include "manchester_pulse_decoder_assert.svh"

module manchester_pulse_decoder #(
  parameter int HEADER_PULSES = mpd_pkg::HEADER_PULSES_DEF,
  parameter int MAX_BITS      = mpd_pkg::MAX_BITS_DEF,
  parameter int SYNC_PULSES   = mpd_pkg::SYNC_PULSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mpd_pkg::in_item_t              in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mpd_pkg::out_item_t             out_res,
  input  logic                           cfg_en,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  mpd_pkg::cfg_t       cfg;
  mpd_pkg::meter_ctl_t mctl;
  mpd_pkg::pulse_t     pulse;
  mpd_pkg::in_item_t   in_q;
  logic                in_q_valid;
  logic                advance;
  logic                fire;
  logic                res_valid;
  mpd_pkg::out_item_t  res;

  assign advance  = !out_valid || !out_stall;
  assign fire     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire ? res_valid : (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

  mpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mpd_meter u_meter (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ctl    (mctl),
    .sample (in_q.sample),
    .pulse  (pulse)
  );

  mpd_frame #(
    .HEADER_PULSES (HEADER_PULSES),
    .MAX_BITS      (MAX_BITS),
    .SYNC_PULSES   (SYNC_PULSES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .item      (in_q),
    .pulse     (pulse),
    .mctl      (mctl),
    .res_valid (res_valid),
    .res       (res)
  );

  `MPD_ASSERT_NOW(a_stall_only_when_full, clk, rst, in_stall,
    in_q_valid && out_valid && out_stall, "input stalled with a free stage")
  `MPD_ASSERT_NOW(a_empty_result_ends_frame, clk, rst,
    out_valid && out_res.bit_total == 2'd0, out_res.frame_done,
    "result without bits does not end the frame")
  `MPD_ASSERT_NOW(a_error_has_no_bits, clk, rst,
    out_valid && out_res.status != mpd_pkg::ST_COMPLETE,
    out_res.frame_done && out_res.bit_total == 2'd0,
    "error status on a result carrying bits")
  `MPD_ASSERT_NEXT(a_no_result_from_start, clk, rst,
    fire && in_q.op == mpd_pkg::OP_START, !out_valid || $stable(out_res),
    "start request produced a result")

endmodule

### test/testbench.sv
// Self-checking testbench for the Manchester pulse-width decoder.
module testbench;
  import mpd_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int QUIET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int ITEM_TARGET  = 520;

  typedef enum int {
    FR_GOOD,
    FR_OVERSHOOT,
    FR_NO_HEADER,
    FR_BAD_SYNC,
    FR_SHORT,
    FR_RESTART,
    FR_NOISE
  } frame_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_res;
  logic                  cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow
  logic [SAMPLE_W-1:0] cfg_low = LOW_THR_RST;
  logic [SAMPLE_W-1:0] cfg_high = HIGH_THR_RST;
  logic [HALF_W-1:0]   cfg_half = HALF_PERIOD_RST;
  logic [TOL_W-1:0]    cfg_tol = TOLERANCE_RST;
  logic [BITS_W-1:0]   cfg_want = EXP_BITS_RST;
  logic [SETTLE_W-1:0] cfg_settle = SETTLE_RST;

  // decoder state
  phase_t              dec_phase = PH_IDLE;
  logic                dec_fall = 1'b0;
  logic [1:0]          meter_step = '0;
  tick_t               meter_timeout = '0;
  tick_t               meter_len = '0;
  logic [SETTLE_W-1:0] settle_left = '0;
  logic [4:0]          header_misses = '0;
  logic [1:0]          sync_seen = '0;
  logic [BITS_W-1:0]   bits_decoded = '0;

  in_item_t  tick_queue[$];
  out_item_t decoded_due[$];
  int        reqs_queued = 0;
  int        mismatches = 0;
  logic      gen_fall = 1'b0;

  int        burst_left = 1;
  int        gap_left = 0;
  int        cycle_count = 0;
  int        stall_mode = 0;
  int        stall_left = 0;
  logic      stall_pat;
  out_item_t want_res;
  int        hold_left = 0;
  logic      hold_armed = 1'b0;
  logic      hold_taken = 1'b0;

  manchester_pulse_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit in_window(int p, int len);
    int lo;
    lo = (len > int'(cfg_tol)) ? len - int'(cfg_tol) : 0;
    return p >= lo && p <= len + int'(cfg_tol);
  endfunction

  function automatic int bit_target();
    int t;
    t = int'(cfg_want);
    if (t > MAX_BITS_DEF) t = MAX_BITS_DEF;
    if (t > TARGET_CAP) t = TARGET_CAP;
    return t;
  endfunction

  function automatic void meter_restart();
    meter_step = '0;
    meter_timeout = '0;
    meter_len = '0;
  endfunction

  function automatic void close_frame(logic [1:0] pair, logic [1:0] total, int index,
                                      logic done, status_t status);
    out_item_t res;
    res.bit_pair = pair;
    res.bit_total = total;
    res.bit_index = index[BITS_W-1:0];
    res.frame_done = done;
    res.status = status;
    decoded_due.push_back(res);
    if (done) dec_phase = PH_IDLE;
  endfunction

  // One accepted tick through the meter and the frame sequencer.
  function automatic void decode_tick(in_item_t req);
    int         h, len, first;
    logic       want_high, hit, got;
    logic [1:0] pair, total;
    h = int'(cfg_half);
    if (req.op == OP_START) begin
      dec_fall = 1'b0;
      meter_restart();
      header_misses = '0;
      sync_seen = '0;
      bits_decoded = '0;
      settle_left = cfg_settle;
      dec_phase = (cfg_settle == 0) ? PH_HEADER : PH_SETTLE;
      return;
    end
    if (dec_phase == PH_SETTLE) begin
      if (settle_left != 0) settle_left--;
      if (settle_left == 0) dec_phase = PH_HEADER;
      return;
    end
    if (dec_phase == PH_IDLE) return;

    got = 1'b0;
    len = 0;
    meter_timeout++;
    if (int'(meter_timeout) > 8 * h) begin
      got = 1'b1;
      meter_restart();
    end else begin
      if (meter_step != 0) meter_len++;
      want_high = (meter_step != 1) == !dec_fall;
      hit = want_high ? (req.sample >= cfg_high) : (req.sample <= cfg_low);
      if (hit) begin
        if (meter_step == 0) meter_len = '0;
        meter_step++;
        if (meter_step == 3) begin
          len = int'(meter_len);
          got = 1'b1;
          meter_restart();
        end
      end
    end
    if (!got) return;

    case (dec_phase)
      PH_HEADER: begin
        if (in_window(len, 3 * h)) begin
          dec_phase = PH_SYNC;
          sync_seen = '0;
        end else begin
          header_misses++;
          if (header_misses >= HEADER_PULSES_DEF)
            close_frame(2'd0, 2'd0, 0, 1'b1, ST_NO_HEADER);
        end
      end
      PH_SYNC: begin
        if (!in_window(len, 2 * h)) begin
          close_frame(2'd0, 2'd0, 0, 1'b1, ST_SYNC_BAD);
        end else begin
          sync_seen++;
          if (sync_seen >= SYNC_PULSES_DEF) begin
            dec_phase = PH_DATA;
            bits_decoded = '0;
            if (bit_target() == 0) close_frame(2'd0, 2'd0, 0, 1'b1, ST_COMPLETE);
          end
        end
      end
      default: begin
        first = int'(bits_decoded);
        if (in_window(len, 2 * h)) begin
          pair = {1'b0, dec_fall};
          total = 2'd1;
        end else if (in_window(len, 3 * h)) begin
          // 1.5-bit pulse: polarity of the measured edge flips
          pair = dec_fall ? 2'b00 : 2'b11;
          total = 2'd2;
          dec_fall = !dec_fall;
        end else if (in_window(len, 4 * h)) begin
          pair = dec_fall ? 2'b01 : 2'b10;
          total = 2'd2;
        end else begin
          close_frame(2'd0, 2'd0, first, 1'b1, ST_SHORT);
          return;
        end
        bits_decoded += total;
        close_frame(pair, total, first, int'(bits_decoded) >= bit_target(), ST_COMPLETE);
      end
    endcase
  endfunction

  function automatic void push_req(op_t op, logic [SAMPLE_W-1:0] sample);
    in_item_t req;
    req.op = op;
    req.sample = sample;
    tick_queue.push_back(req);
    reqs_queued++;
  endfunction

  function automatic logic [SAMPLE_W-1:0] level(logic high);
    return high ? 8'($urandom_range(255, cfg_high)) : 8'($urandom_range(cfg_low, 0));
  endfunction

  // Jitter kept below half a half-period so the pulse classes stay apart.
  function automatic int jitter(int len);
    int amp;
    amp = (int'(cfg_half) - 1) / 2;
    if (int'(cfg_tol) < amp) amp = int'(cfg_tol);
    if (amp < 0) amp = 0;
    return len + int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  // lead level, other level, then one lead sample that closes the measurement
  function automatic void queue_pulse(int len);
    int lead;
    if (len < 2) len = 2;
    lead = len / 2;
    repeat (lead) push_req(OP_SAMPLE, level(!gen_fall));
    repeat (len - lead) push_req(OP_SAMPLE, level(gen_fall));
    push_req(OP_SAMPLE, level(!gen_fall));
  endfunction

  // Pulse that fails the check of the current step: picks from 2H, 4H, 6H, timeout.
  function automatic void queue_bad(int first);
    int h, pick;
    h = int'(cfg_half);
    pick = $urandom_range(first, 3);
    if (pick == 3 && h > 16) pick = 2;
    case (pick)
      0: queue_pulse(2 * h);
      1: queue_pulse(4 * h);
      2: queue_pulse(6 * h);
      default: repeat (8 * h + 1) push_req(OP_SAMPLE, level(!gen_fall));
    endcase
  endfunction

  function automatic void queue_frame(frame_kind_t kind);
    int h, goal, bits, cut, step;
    h = int'(cfg_half);
    gen_fall = 1'b0;
    push_req(OP_START, 8'($urandom));
    repeat (int'(cfg_settle)) push_req(OP_SAMPLE, 8'($urandom));
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(20, 300)) push_req(OP_SAMPLE, 8'($urandom));
      return;
    end
    if (kind == FR_NO_HEADER) begin
      repeat (HEADER_PULSES_DEF) queue_bad(0);
      return;
    end
    repeat ($urandom_range(0, 3)) queue_bad(0);
    queue_pulse(jitter(3 * h));
    if (kind == FR_BAD_SYNC) begin
      repeat ($urandom_range(0, SYNC_PULSES_DEF - 1)) queue_pulse(jitter(2 * h));
      queue_bad(1);
      return;
    end
    repeat (SYNC_PULSES_DEF) queue_pulse(jitter(2 * h));
    goal = bit_target();
    cut = ((kind == FR_SHORT || kind == FR_RESTART) && goal > 0) ?
          $urandom_range(0, goal - 1) : -1;
    bits = 0;
    while (bits < goal) begin
      if (cut >= 0 && bits >= cut) begin
        // restart frames just stop here; the next start cuts in
        if (kind == FR_SHORT) queue_bad(2);
        return;
      end
      step = (kind == FR_OVERSHOOT && bits == goal - 1) ? 2 : $urandom_range(0, 2);
      case (step)
        0: begin
          queue_pulse(jitter(2 * h));
          bits += 1;
        end
        1: begin
          queue_pulse(jitter(3 * h));
          gen_fall = !gen_fall;
          bits += 2;
        end
        default: begin
          queue_pulse(jitter(4 * h));
          bits += 2;
        end
      endcase
    end
    repeat ($urandom_range(0, 5)) push_req(OP_SAMPLE, 8'($urandom));
  endfunction

  task automatic write_reg(cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_LOW_THR:     cfg_low = value[SAMPLE_W-1:0];
      CFG_HIGH_THR:    cfg_high = value[SAMPLE_W-1:0];
      CFG_HALF_PERIOD: cfg_half = value[HALF_W-1:0];
      CFG_TOLERANCE:   cfg_tol = value[TOL_W-1:0];
      CFG_EXP_BITS:    cfg_want = value[BITS_W-1:0];
      default:         cfg_settle = value[SETTLE_W-1:0];
    endcase
  endtask

  task automatic set_config(int low, int high, int half, int tol, int want, int settle);
    write_reg(CFG_LOW_THR, low);
    write_reg(CFG_HIGH_THR, high);
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_EXP_BITS, want);
    write_reg(CFG_SETTLE, settle);
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  // Drain: every tick taken, every result seen, pipeline flushed.
  task automatic wait_quiet();
    while (tick_queue.size() != 0 || in_valid || decoded_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) decode_tick(in_req);
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        in_req <= tick_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) :
                       $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end
  end

  // result monitor and stall pattern
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      if (!rst && out_valid && !out_stall) begin
        if (decoded_due.size() == 0) begin
          $error("result arrived with nothing expected: %p", out_res);
          mismatches++;
        end else begin
          want_res = decoded_due.pop_front();
          if (out_res.bit_pair !== want_res.bit_pair) begin
            $error("bit_pair expected %0d got %0d", want_res.bit_pair, out_res.bit_pair);
            mismatches++;
          end
          if (out_res.bit_total !== want_res.bit_total) begin
            $error("bit_total expected %0d got %0d", want_res.bit_total, out_res.bit_total);
            mismatches++;
          end
          if (out_res.bit_index !== want_res.bit_index) begin
            $error("bit_index expected %0d got %0d", want_res.bit_index, out_res.bit_index);
            mismatches++;
          end
          if (out_res.frame_done !== want_res.frame_done) begin
            $error("frame_done expected %0d got %0d", want_res.frame_done,
                   out_res.frame_done);
            mismatches++;
          end
          if (out_res.status !== want_res.status) begin
            $error("status expected %0d got %0d", want_res.status, out_res.status);
            mismatches++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       stall_pat = 1'b0;
        1:       stall_pat = ($urandom_range(0, 7) == 0);
        2:       stall_pat = $urandom_range(0, 1);
        default: stall_pat = ($urandom_range(0, 7) != 0);
      endcase
      out_stall <= (hold_left != 0) || stall_pat;
    end
  end

  initial begin
    int          h, tol, low, high, want, settle, r;
    frame_kind_t kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // samples with no frame running are dropped
    push_req(OP_SAMPLE, 8'h00);
    push_req(OP_SAMPLE, 8'hFF);
    repeat (3) push_req(OP_SAMPLE, 8'($urandom));
    wait_quiet();

    // no settle time, odd bit count ending in a two-bit pulse
    set_config(100, 150, 2, 0, 5, 0);
    queue_frame(FR_OVERSHOOT);
    wait_quiet();

    // zero bits wanted, missing header, bad sync
    set_config(60, 200, 1, 0, 0, 3);
    queue_frame(FR_GOOD);
    queue_frame(FR_NO_HEADER);
    queue_frame(FR_BAD_SYNC);
    wait_quiet();

    set_config(60, 200, 1, 0, 6, 3);
    queue_frame(FR_SHORT);
    queue_frame(FR_RESTART);
    wait_quiet();

    // zero half period: a pulse every tick, bit count above the cap,
    // results pile up under the hold
    set_config(255, 0, 0, 0, 127, 2);
    hold_armed = 1'b1;
    queue_frame(FR_GOOD);
    wait_quiet();

    // widest register values; the frame stays in its settle time
    set_config(114, 140, 511, 255, 1, 4095);
    push_req(OP_START, 8'($urandom));
    repeat (20) push_req(OP_SAMPLE, 8'($urandom));
    wait_quiet();

    while (reqs_queued < ITEM_TARGET) begin
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      tol = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
            $urandom_range(0, (h - 1) / 2);
      low = $urandom_range(0, 200);
      high = $urandom_range(low + 1, 255);
      want = $urandom_range(0, 12);
      settle = $urandom_range(0, 6);
      set_config(low, high, h, tol, want, settle);
      repeat ($urandom_range(1, 2)) begin
        r = $urandom_range(0, 99);
        kind = (r < 55) ? FR_GOOD :
               (r < 63) ? FR_OVERSHOOT :
               (r < 72) ? FR_SHORT :
               (r < 80) ? FR_BAD_SYNC :
               (r < 86) ? FR_NO_HEADER :
               (r < 93) ? FR_RESTART : FR_NOISE;
        queue_frame(kind);
      end
      wait_quiet();
    end

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mpd_pkg.sv
rtl/mpd_cfg.sv
rtl/mpd_meter.sv
rtl/mpd_frame.sv
rtl/manchester_pulse_decoder.sv
test/testbench.sv
